// File: hw/rtl/urbe_pkg.sv
// Shared types and constants for the UART ring buffer engine.
// Depends on nothing; every other file imports it.
package urbe_pkg;

    localparam int RING_DEPTH = 64;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef enum logic [1:0] {
        KIND_RX_BYTE  = 2'd0,
        KIND_HOST_RD  = 2'd1,
        KIND_HOST_WR  = 2'd2,
        KIND_TX_READY = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       read_valid;
        logic [7:0] send_byte;
        logic       send_valid;
        logic       rx_nonempty;
        logic       tx_busy;
    } rsp_t;

    // Control into one ring.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } ring_ctl_t;

    function automatic ptr_t ring_next(input ptr_t p);
        ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// File: hw/rtl/urbe_ring.sv
// One overwrite-oldest byte ring: a synchronous memory plus head and tail pointers.
// Depends on urbe_pkg.
module urbe_ring
    import urbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ring_ctl_t ctl,
    output logic      nonempty,
    output logic [7:0] rdata
);

    logic [7:0] mem [RING_DEPTH];
    logic [7:0] rdata_reg;
    ptr_t       head_reg, head_next;
    ptr_t       tail_reg, tail_next;

    // A push that catches up with the tail drops the oldest byte.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (ctl.push)
        begin
            head_next = ring_next(head_reg);
            if (head_next == tail_reg)
            begin
                tail_next = ring_next(tail_reg);
            end
        end
        else if (ctl.pop)
        begin
            tail_next = ring_next(tail_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[head_reg] <= ctl.wdata;
        end
        if (ctl.pop)
        begin
            rdata_reg <= mem[tail_reg];
        end
    end

    assign nonempty = (head_reg != tail_reg);
    assign rdata    = rdata_reg;

endmodule

// File: hw/rtl/uart_ring_buffer_engine_top.sv
// Top level of the UART ring buffer engine: event decode, result register, two rings.
// Depends on urbe_pkg and urbe_ring.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_t  (kind, data)
//   rsp      out        rsp_valid / rsp_ready  rsp_t  (read/send bytes, flags)
//
// Every request passes through S_IDLE and then S_RESULT: in S_IDLE the pointers move and a pop
// issues its memory read; in S_RESULT the registered memory data and the
// updated ring status are folded into the result register. The registered memory read
// of the rings is why S_RESULT is needed.
// Reset clears pointers, the busy flag and the control state; ring contents
// are left undefined, since only written entries are ever read.
// A new request is taken in S_IDLE once the result register is empty or being drained,
// so a stalled response holds off further requests.
module uart_ring_buffer_engine_top
    import urbe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_RESULT = 2'b10
    } state_t;

    // What the result of the request in flight is made of.
    typedef struct packed {
        logic       rd_mem;     // read_byte comes from the receive ring
        logic       sd_mem;     // send_byte comes from the transmit ring
        logic       sd_direct;  // send_byte is the host byte itself
        logic [7:0] data;
    } pend_t;

    state_t    state_reg, state_next;
    pend_t     pend_reg, pend_next;
    logic      busy_reg, busy_next;
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_t      rsp_reg, rsp_next;
    ring_ctl_t rx_ctl, tx_ctl;
    logic      rx_nonempty, tx_nonempty;
    logic [7:0] rx_rdata, tx_rdata;
    logic      accept;

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    // Decode the request into ring operations and the pending result.
    always_comb
    begin
        rx_ctl    = '{push: 1'b0, pop: 1'b0, wdata: req.data};
        tx_ctl    = '{push: 1'b0, pop: 1'b0, wdata: req.data};
        pend_next = pend_reg;
        busy_next = busy_reg;
        if (accept)
        begin
            pend_next = '{rd_mem: 1'b0, sd_mem: 1'b0, sd_direct: 1'b0, data: req.data};
            case (kind_t'(req.kind))
                KIND_RX_BYTE:
                begin
                    rx_ctl.push = 1'b1;
                end
                KIND_HOST_RD:
                begin
                    // An empty ring leaves everything untouched.
                    if (rx_nonempty)
                    begin
                        rx_ctl.pop       = 1'b1;
                        pend_next.rd_mem = 1'b1;
                    end
                end
                KIND_HOST_WR:
                begin
                    if (!busy_reg)
                    begin
                        pend_next.sd_direct = 1'b1;
                        busy_next           = 1'b1;
                    end
                    else
                    begin
                        tx_ctl.push = 1'b1;
                    end
                end
                KIND_TX_READY:
                begin
                    if (tx_nonempty)
                    begin
                        tx_ctl.pop       = 1'b1;
                        pend_next.sd_mem = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencing and the result register.
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                state_next           = S_IDLE;
                rsp_valid_next       = 1'b1;
                rsp_next.read_byte   = pend_reg.rd_mem ? rx_rdata : 8'd0;
                rsp_next.read_valid  = pend_reg.rd_mem;
                rsp_next.send_byte   = pend_reg.sd_mem    ? tx_rdata :
                                       pend_reg.sd_direct ? pend_reg.data : 8'd0;
                rsp_next.send_valid  = pend_reg.sd_mem || pend_reg.sd_direct;
                rsp_next.rx_nonempty = rx_nonempty;
                rsp_next.tx_busy     = busy_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    urbe_ring u_rx_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rx_ctl),
        .nonempty (rx_nonempty),
        .rdata    (rx_rdata)
    );

    urbe_ring u_tx_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (tx_ctl),
        .nonempty (tx_nonempty),
        .rdata    (tx_rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: hw/rtl/urbe_checker.sv
// Port-level checks for the UART ring buffer engine, bound to its top level.
// Depends on urbe_pkg and uart_ring_buffer_engine_top.
module urbe_checker
    import urbe_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // A waiting request keeps its valid and its payload.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request changed while waiting");

    // A stalled response holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // Once a request is taken, req_ready drops while the block finishes it.
    a_req_gap: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken in back-to-back cycles");

    // Bytes are zero unless their valid flag is set.
    a_zero_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.read_valid || rsp.read_byte == 8'd0) &&
                      (rsp.send_valid || rsp.send_byte == 8'd0))
        else $error("byte field set without its valid flag");

    // A send only happens with the transmitter marked busy, and a request
    // never both reads and sends.
    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp.send_valid || rsp.tx_busy) &&
                      !(rsp.send_valid && rsp.read_valid))
        else $error("send without busy flag, or read and send together");

endmodule

bind uart_ring_buffer_engine_top urbe_checker u_urbe_checker (.*);

// File: test/uart_ring_buffer_engine_top_tb.sv
// Self-checking testbench for uart_ring_buffer_engine_top: directed, ring-overflow and
// random request traffic, each response checked against an in-bench predictor.
// Depends on urbe_pkg and the RTL of uart_ring_buffer_engine_top.
module uart_ring_buffer_engine_top_tb
    import urbe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Generous bound on the whole run. The slowest correct run is roughly 410
    // requests, with long sender gaps in one phase and an 85 percent receiver stall in another.
    localparam int CYCLE_LIMIT = 200000;
    // The block registers its answer after a request is taken; wait a little longer at the end.
    localparam int DRAIN_CYCLES = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;

    // Predicted state of both rings and of the transmitter flag.
    logic [7:0] rx_bytes [RING_DEPTH];
    logic [7:0] tx_bytes [RING_DEPTH];
    ptr_t rx_wr;
    ptr_t rx_rd;
    ptr_t tx_wr;
    ptr_t tx_rd;
    logic tx_active;

    // Responses still owed by the block, oldest first.
    rsp_t uart_replies_due [$];

    uart_ring_buffer_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("uart_ring_buffer_engine_top_tb: FAIL");
            $finish;
        end
    end

    // The response side stalls at random; the percentage is set per phase.
    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic ptr_t step_ptr(input ptr_t p);
        step_ptr = ptr_t'((int'(p) + 1) % RING_DEPTH);
    endfunction

    function automatic void clear_buffer_state();
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            rx_bytes[i] = '0;
            tx_bytes[i] = '0;
        end
        rx_wr = '0;
        rx_rd = '0;
        tx_wr = '0;
        tx_rd = '0;
        tx_active = 1'b0;
    endfunction

    // Works out the response to one accepted request and moves the predicted
    // state on. A push that catches up with the read pointer drops the oldest byte.
    function automatic rsp_t apply_uart_event(input req_t r);
        rsp_t out;
        out = '0;
        case (kind_t'(r.kind))
            KIND_RX_BYTE:
            begin
                rx_bytes[rx_wr] = r.data;
                rx_wr = step_ptr(rx_wr);
                if (rx_wr == rx_rd)
                    rx_rd = step_ptr(rx_rd);
            end
            KIND_HOST_RD:
            begin
                // An empty ring answers with nothing and keeps its pointers.
                if (rx_wr != rx_rd)
                begin
                    out.read_byte = rx_bytes[rx_rd];
                    out.read_valid = 1'b1;
                    rx_rd = step_ptr(rx_rd);
                end
            end
            KIND_HOST_WR:
            begin
                // An idle transmitter takes the byte at once; a busy one queues it.
                if (!tx_active)
                begin
                    out.send_byte = r.data;
                    out.send_valid = 1'b1;
                    tx_active = 1'b1;
                end
                else
                begin
                    tx_bytes[tx_wr] = r.data;
                    tx_wr = step_ptr(tx_wr);
                    if (tx_wr == tx_rd)
                        tx_rd = step_ptr(tx_rd);
                end
            end
            default:
            begin
                // Transmitter ready: send the next queued byte, or go idle.
                if (tx_rd != tx_wr)
                begin
                    out.send_byte = tx_bytes[tx_rd];
                    out.send_valid = 1'b1;
                    tx_rd = step_ptr(tx_rd);
                end
                else
                begin
                    tx_active = 1'b0;
                end
            end
        endcase
        out.rx_nonempty = (rx_wr != rx_rd);
        out.tx_busy = tx_active;
        return out;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Every accepted response is held against the oldest owed one, field by field.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (uart_replies_due.size() == 0)
            begin
                $error("response with none outstanding: %p", rsp);
                fail_count++;
            end
            else
            begin
                want = uart_replies_due.pop_front();
                check_field("read_byte", want.read_byte, rsp.read_byte);
                check_field("read_valid", 8'(want.read_valid), 8'(rsp.read_valid));
                check_field("send_byte", want.send_byte, rsp.send_byte);
                check_field("send_valid", 8'(want.send_valid), 8'(rsp.send_valid));
                check_field("rx_nonempty", 8'(want.rx_nonempty), 8'(rsp.rx_nonempty));
                check_field("tx_busy", 8'(want.tx_busy), 8'(rsp.tx_busy));
            end
        end
    end

    // Sends one request. Called at a falling edge and returns at one. The valid
    // line is touched once per falling edge, so back-to-back requests keep it high.
    task automatic send_req(input kind_t k, input logic [7:0] d);
        req_t r;
        r.kind = k;
        r.data = d;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        uart_replies_due.push_back(apply_uart_event(r));
        @(negedge clk);
    endtask

    task automatic set_pace(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Short walk over each event and its corner: empty reads, idle and busy
    // writes, the transmitter going idle, and data bytes at both extremes.
    task automatic test_directed();
        send_req(KIND_HOST_RD, 8'h00);   // read on an empty ring
        send_req(KIND_HOST_RD, 8'hFF);   // data is ignored on a read
        send_req(KIND_TX_READY, 8'hFF);  // ready while already idle
        send_req(KIND_RX_BYTE, 8'h00);
        send_req(KIND_RX_BYTE, 8'hFF);
        send_req(KIND_HOST_RD, 8'h00);
        send_req(KIND_HOST_RD, 8'h00);
        send_req(KIND_HOST_RD, 8'h00);   // drained again
        send_req(KIND_HOST_WR, 8'hA5);   // idle: goes straight out
        send_req(KIND_HOST_WR, 8'h5A);   // busy: queued
        send_req(KIND_HOST_WR, 8'hFF);
        send_req(KIND_HOST_WR, 8'h00);
        send_req(KIND_TX_READY, 8'h00);
        send_req(KIND_TX_READY, 8'h00);
        send_req(KIND_TX_READY, 8'h00);
        send_req(KIND_TX_READY, 8'h00);  // queue empty: busy clears
        send_req(KIND_HOST_WR, 8'h3C);   // idle once more
        send_req(KIND_RX_BYTE, 8'h81);
        send_req(KIND_TX_READY, 8'h00);
        send_req(KIND_HOST_RD, 8'h7E);
    endtask

    // Pushes both rings past their capacity so the oldest bytes get dropped,
    // then drains them and runs a few events beyond empty.
    task automatic test_ring_overflow();
        for (int i = 0; i < RING_DEPTH + 6; i++)
            send_req(KIND_RX_BYTE, 8'($urandom_range(0, 255)));
        for (int i = 0; i < RING_DEPTH + 2; i++)
            send_req(KIND_HOST_RD, 8'($urandom_range(0, 255)));
        send_req(KIND_HOST_WR, 8'($urandom_range(0, 255)));
        for (int i = 0; i < RING_DEPTH + 6; i++)
            send_req(KIND_HOST_WR, 8'($urandom_range(0, 255)));
        for (int i = 0; i < RING_DEPTH + 2; i++)
            send_req(KIND_TX_READY, 8'($urandom_range(0, 255)));
    endtask

    // Random traffic in bursts that lean toward filling, draining or neither,
    // so the rings wander between empty and full.
    task automatic test_random_traffic(input int count);
        int sent;
        int burst_len;
        int lean;
        int roll;
        kind_t k;
        sent = 0;
        while (sent < count)
        begin
            burst_len = $urandom_range(5, 40);
            lean = $urandom_range(0, 2);
            for (int i = 0; i < burst_len && sent < count; i++)
            begin
                roll = $urandom_range(0, 99);
                if (lean == 1)
                    k = (roll < 45) ? KIND_RX_BYTE : (roll < 90) ? KIND_HOST_WR
                        : kind_t'($urandom_range(0, 3));
                else if (lean == 2)
                    k = (roll < 45) ? KIND_HOST_RD : (roll < 90) ? KIND_TX_READY
                        : kind_t'($urandom_range(0, 3));
                else
                    k = kind_t'($urandom_range(0, 3));
                send_req(k, 8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    initial
    begin
        clear_buffer_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Slow sender against a heavily stalled receiver first.
        set_pace(24, 85);
        test_directed();
        test_ring_overflow();
        test_random_traffic(40);

        // Then the other way round, then full speed on both sides.
        set_pace(85, 24);
        test_random_traffic(40);
        set_pace(0, 0);
        test_random_traffic(40);

        req_valid <= 1'b0;
        while (uart_replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("uart_ring_buffer_engine_top_tb: PASS");
        else
            $display("uart_ring_buffer_engine_top_tb: FAIL");
        $finish;
    end

endmodule
